// ===== hw/rtl/rsl_pkg.sv =====
// shared types, constants and character helpers for the return statement lexer
package rsl_pkg;

  // scan modes of the lexer
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_IDENT  = 3'd4,
    MODE_NUMBER = 3'd5
  } mode_t;

  // token kinds, none marks an empty history slot
  typedef enum logic [1:0] {
    KIND_RETURN = 2'd0,
    KIND_NUMBER = 2'd1,
    KIND_SEMI   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  localparam int unsigned VAL_W   = 31;
  localparam int unsigned QDEPTH  = 3;
  localparam int unsigned QCNT_W  = 2;
  localparam logic [2:0]  KW_LEN  = 3'd6;
  localparam logic [VAL_W-1:0] NUM_MAX = {VAL_W{1'b1}};

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;

  // one result transaction
  typedef struct packed {
    kind_t            kind;
    logic [VAL_W-1:0] value;
    logic             ok;
    logic             exit_found;
    logic [VAL_W-1:0] exit_code;
    logic             last;
  } token_t;

  // token history used for exit statement detection
  typedef struct packed {
    kind_t            p1;
    kind_t            p2;
    logic [VAL_W-1:0] held;
    logic             hok;
  } hist_t;

  // tokens produced by one source byte, in delivery order
  typedef struct packed {
    token_t             t0;
    token_t             t1;
    logic [QCNT_W-1:0]  count;
  } step_out_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ);
  endfunction

  // letters of the keyword return by position
  function automatic logic [7:0] kw_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h72;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h75;
      3'd4:    c = 8'h72;
      3'd5:    c = 8'h6E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/rsl_core.sv =====
// lexer state and per-byte token generation
module rsl_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         src_byte,
  input  logic               eos,
  output rsl_pkg::step_out_t step
);
  import rsl_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic             star_r, star_nxt;
  logic [2:0]       kpos_r, kpos_nxt;
  logic             kmiss_r, kmiss_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic             ovf_r, ovf_nxt;
  hist_t            hist_r, hist_nxt;

  // lexer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      star_r  <= 1'b0;
      kpos_r  <= 3'd0;
      kmiss_r <= 1'b0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      hist_r  <= '{p1: KIND_NONE, p2: KIND_NONE, held: '0, hok: 1'b0};
    end else if (accept) begin
      mode_r  <= mode_nxt;
      star_r  <= star_nxt;
      kpos_r  <= kpos_nxt;
      kmiss_r <= kmiss_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      hist_r  <= hist_nxt;
    end
  end

  // scan one byte: pending finish (a), semicolon (b), end-of-source finish (c)
  always_comb begin : scan
    logic             relex;
    logic             fin_ok;
    logic [3:0]       dig;
    logic [VAL_W+3:0] prod;
    logic             a_v, b_v, c_v;
    token_t           a_t, c_t, b_t, s0, s1;
    hist_t            h;

    mode_nxt  = mode_r;
    star_nxt  = star_r;
    kpos_nxt  = kpos_r;
    kmiss_nxt = kmiss_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    relex     = 1'b0;
    a_v       = 1'b0;
    b_v       = 1'b0;
    c_v       = 1'b0;
    a_t       = '0;
    b_t       = '0;
    c_t       = '0;
    dig       = 4'(src_byte - CH_ZERO);
    prod      = ((VAL_W+4)'(acc_r) << 3) + ((VAL_W+4)'(acc_r) << 1) + (VAL_W+4)'(dig);
    fin_ok    = 1'b0;

    unique case (mode_r)
      MODE_SLASH: begin
        if (src_byte == CH_SLASH) begin
          mode_nxt = MODE_LINE;
        end else if (src_byte == CH_STAR) begin
          mode_nxt = MODE_BLOCK;
          star_nxt = 1'b0;
        end else begin
          relex = 1'b1;
        end
      end
      MODE_LINE: begin
        if (src_byte == CH_NL) mode_nxt = MODE_NORMAL;
      end
      MODE_BLOCK: begin
        if (star_r && src_byte == CH_SLASH) begin
          mode_nxt = MODE_NORMAL;
          star_nxt = 1'b0;
        end else if (eos) begin
          star_nxt = 1'b0;
          relex    = 1'b1;
        end else begin
          star_nxt = (src_byte == CH_STAR);
        end
      end
      MODE_IDENT: begin
        if (is_alpha(src_byte) || is_digit(src_byte) || src_byte == CH_UNDER) begin
          if (kpos_r < KW_LEN && src_byte == kw_char(kpos_r)) kpos_nxt = kpos_r + 3'd1;
          else kmiss_nxt = 1'b1;
        end else begin
          a_v      = !kmiss_r && kpos_r == KW_LEN;
          a_t.kind = KIND_RETURN;
          relex    = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(src_byte)) begin
          if (!ovf_r) begin
            if (prod > (VAL_W+4)'(NUM_MAX)) begin
              ovf_nxt = 1'b1;
              acc_nxt = '0;
            end else begin
              acc_nxt = prod[VAL_W-1:0];
            end
          end
        end else begin
          a_v      = 1'b1;
          a_t.kind = KIND_NUMBER;
          a_t.value = ovf_r ? '0 : acc_r;
          a_t.ok   = !ovf_r;
          relex    = 1'b1;
        end
      end
      default: relex = 1'b1;
    endcase

    // ordinary lexing of the byte
    if (relex) begin
      mode_nxt = MODE_NORMAL;
      if (is_space(src_byte)) begin
        mode_nxt = MODE_NORMAL;
      end else if (src_byte == CH_SLASH) begin
        mode_nxt = MODE_SLASH;
      end else if (is_alpha(src_byte) || src_byte == CH_UNDER) begin
        mode_nxt  = MODE_IDENT;
        kpos_nxt  = (src_byte == kw_char(3'd0)) ? 3'd1 : 3'd0;
        kmiss_nxt = (src_byte != kw_char(3'd0));
      end else if (is_digit(src_byte)) begin
        mode_nxt = MODE_NUMBER;
        acc_nxt  = VAL_W'(dig);
        ovf_nxt  = 1'b0;
      end else if (src_byte == CH_SEMI) begin
        b_v      = 1'b1;
        b_t.kind = KIND_SEMI;
      end
    end

    // end of source finishes what is pending
    if (eos) begin
      if (mode_nxt == MODE_IDENT) begin
        c_v      = !kmiss_nxt && kpos_nxt == KW_LEN;
        c_t.kind = KIND_RETURN;
      end else if (mode_nxt == MODE_NUMBER) begin
        c_v       = 1'b1;
        c_t.kind  = KIND_NUMBER;
        c_t.value = ovf_nxt ? '0 : acc_nxt;
        c_t.ok    = !ovf_nxt;
      end
    end

    // compact into delivery order, at most two are ever live
    s0 = a_v ? a_t : (b_v ? b_t : c_t);
    s1 = b_v ? b_t : c_t;
    step.count = QCNT_W'({1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v});
    fin_ok     = step.count > QCNT_W'(1);

    // exit statement detection over the history
    h = hist_r;
    if (step.count != '0) begin
      if (s0.kind == KIND_SEMI && h.p2 == KIND_RETURN && h.p1 == KIND_NUMBER && h.hok) begin
        s0.exit_found = 1'b1;
        s0.exit_code  = h.held;
      end
      if (s0.kind == KIND_NUMBER) begin
        h.held = s0.value;
        h.hok  = s0.ok;
      end
      h.p2 = h.p1;
      h.p1 = s0.kind;
    end
    if (fin_ok) begin
      if (s1.kind == KIND_SEMI && h.p2 == KIND_RETURN && h.p1 == KIND_NUMBER && h.hok) begin
        s1.exit_found = 1'b1;
        s1.exit_code  = h.held;
      end
      if (s1.kind == KIND_NUMBER) begin
        h.held = s1.value;
        h.hok  = s1.ok;
      end
      h.p2 = h.p1;
      h.p1 = s1.kind;
    end
    s0.last  = !fin_ok;
    s1.last  = 1'b1;
    step.t0  = s0;
    step.t1  = s1;
    hist_nxt = h;

    // end of source returns everything to reset
    if (eos) begin
      mode_nxt  = MODE_NORMAL;
      star_nxt  = 1'b0;
      kpos_nxt  = 3'd0;
      kmiss_nxt = 1'b0;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
      hist_nxt  = '{p1: KIND_NONE, p2: KIND_NONE, held: '0, hok: 1'b0};
    end
  end

endmodule

// ===== hw/rtl/rsl_outq.sv =====
// three-entry result queue, head register drives the output channel
module rsl_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rsl_pkg::step_out_t step,
  output logic               room,
  output logic               head_valid,
  input  logic               pop_ready,
  output rsl_pkg::token_t    head
);
  import rsl_pkg::*;

  token_t            q_r [QDEPTH];
  token_t            q_nxt [QDEPTH];
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;
  logic [QCNT_W-1:0] base;
  logic [QCNT_W-1:0] n_in;

  assign head_valid = cnt_r != '0;
  assign head       = q_r[0];
  assign pop        = head_valid && pop_ready;
  assign room       = cnt_r < QCNT_W'(2);
  assign n_in       = push ? step.count : '0;
  assign base       = cnt_r - QCNT_W'(pop);

  // shift on pop, then append new tokens behind the survivors
  always_comb begin
    for (int i = 0; i < QDEPTH - 1; i++) begin
      q_nxt[i] = pop ? q_r[i+1] : q_r[i];
    end
    q_nxt[QDEPTH-1] = q_r[QDEPTH-1];
    for (int i = 0; i < QDEPTH; i++) begin
      if (n_in != '0 && QCNT_W'(i) == base) q_nxt[i] = step.t0;
      if (n_in > QCNT_W'(1) && QCNT_W'(i) == base + QCNT_W'(1)) q_nxt[i] = step.t1;
    end
    cnt_nxt = base + n_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) q_r[i] <= q_nxt[i];
  end

endmodule

// ===== hw/rtl/return_statement_lexer.sv =====
// Return statement lexer: takes one source byte per transaction and emits
// return, number and semicolon tokens, flagging a semicolon that closes
// return, valid number, semicolon with that exit code. A byte is taken in
// every cycle while fewer than two tokens wait in the three-entry result
// queue; the scan logic is combinational work on the accepted byte, so
// the sustained rate is one byte per cycle. A byte that yields two
// tokens holds the input off for the following cycle, since the output side
// drains one token per cycle, and longer while the output side is stalled.
// Results are written into the result queue and leave from its head register.
module return_statement_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_source_byte,
  input  logic        in_end_of_source,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_token_kind,
  output logic [30:0] out_number_value,
  output logic        out_number_ok,
  output logic        out_exit_found,
  output logic [30:0] out_exit_code,
  output logic        out_last_of_run
);
  import rsl_pkg::*;

  logic      room;
  logic      accept;
  step_out_t step;
  token_t    head;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  // byte scanner and lexer state
  rsl_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .src_byte (in_source_byte),
    .eos      (in_end_of_source),
    .step     (step)
  );

  // result queue
  rsl_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .step       (step),
    .room       (room),
    .head_valid (out_valid),
    .pop_ready  (!out_stall),
    .head       (head)
  );

  assign out_token_kind   = 2'(head.kind);
  assign out_number_value = head.value;
  assign out_number_ok    = head.ok;
  assign out_exit_found   = head.exit_found;
  assign out_exit_code    = head.exit_code;
  assign out_last_of_run  = head.last;

endmodule
